/* sv/lpd_pkg.sv */
// shared types and constants for the largest differencing partition block
`timescale 1ns / 1ps

package lpd_pkg;

   localparam int VALUE_WIDTH = 64;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // the operation that every cell of the sorted chain carries out
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT2
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      value_type   operand;
   } cell_cmd_type;

endpackage

/* sv/lpd_cell.sv */
// one cell of the descending sorted chain
`timescale 1ns / 1ps

module lpd_cell import lpd_pkg::*; (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         occupied,
   input  logic         left_keep,
   input  value_type    left_value,
   input  value_type    far_value,
   output logic         keep,
   output value_type    value
);

   value_type value_ff;
   value_type value_in;

   // an occupied cell at least as large as the operand stays put on insert
   assign keep  = occupied && (value_ff >= cmd.operand);
   assign value = value_ff;

   always_comb begin
      case (cmd.op)
         CELL_INSERT: begin
            if (keep) begin
               value_in = value_ff;
            end else if (left_keep) begin
               value_in = cmd.operand;
            end else begin
               value_in = left_value;
            end
         end
         CELL_SHIFT2: value_in = far_value;
         default:     value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* sv/largest_differencing_partition.sv */
// top level: karmarkar-karp differencing over a sorted chain of cells
`timescale 1ns / 1ps

// usage
//   req channel: one unsigned 64-bit number per beat; req_last closes the set.
//   numbers load one per cycle, while req_ready is high, into a chain of
//   MAX_NUMBERS cells that stays sorted largest first: every cell compares
//   the new number with its own. a number that finds the chain full is
//   dropped and flagged. after the last beat the block repeats: subtract the
//   two front cells while the chain shifts left by two, then insert the
//   difference, until one number is left; the done step then loads the
//   output register once it is free. req_ready is low during differencing.
//   rsp channel: one beat per set, residue and overflowed, held in an output
//   register; while the receiver stalls, the next set may already load, but
//   its differencing result waits until the register frees.
//   reset (synchronous, active high) empties the chain and clears the drop flag
//   and the output valid; cell contents are not cleared, the count masks them.
//   after each result the count and the drop flag return to zero.

module largest_differencing_partition import lpd_pkg::*; #(
   parameter int MAX_NUMBERS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_residue,
   output logic        rsp_overflowed
);

   localparam int CNT_W = $clog2(MAX_NUMBERS + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SUB,
      ST_INS,
      ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic         dropped_ff, dropped_in;
   value_type    diff_ff, diff_in;
   logic         rsp_valid_ff, rsp_valid_in;
   value_type    rsp_residue_ff, rsp_residue_in;
   logic         rsp_overflowed_ff, rsp_overflowed_in;

   cell_cmd_type cmd;
   logic         keep [MAX_NUMBERS];
   value_type    value [MAX_NUMBERS];

   logic         req_fire;
   logic         room;
   logic [CNT_W-1:0] count_after_load;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign room      = (count_ff < CNT_W'(MAX_NUMBERS));
   assign count_after_load = room ? count_ff + 1'b1 : count_ff;

   // chain of cells, front (largest) at index 0
   for (genvar i = 0; i < MAX_NUMBERS; i++) begin : g_cell
      logic      left_keep;
      value_type left_value;
      value_type far_value;

      if (i == 0) begin : g_front
         assign left_keep  = 1'b1;
         assign left_value = cmd.operand;
      end else begin : g_inner
         assign left_keep  = keep[i-1];
         assign left_value = value[i-1];
      end

      if (i + 2 < MAX_NUMBERS) begin : g_far
         assign far_value = value[i+2];
      end else begin : g_tail
         assign far_value = value[i];
      end

      lpd_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (CNT_W'(i) < count_ff),
         .left_keep  (left_keep),
         .left_value (left_value),
         .far_value  (far_value),
         .keep       (keep[i]),
         .value      (value[i])
      );
   end

   // sequencer: load, subtract / insert until one number is left, then hand off the result
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      dropped_in        = dropped_ff;
      diff_in           = diff_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_residue_in    = rsp_residue_ff;
      rsp_overflowed_in = rsp_overflowed_ff;
      cmd.op            = CELL_HOLD;
      cmd.operand       = diff_ff;

      case (state_ff)
         ST_LOAD: begin
            cmd.operand = req_value;
            if (req_fire) begin
               if (room) begin
                  cmd.op = CELL_INSERT;
               end else begin
                  dropped_in = 1'b1;
               end
               count_in = count_after_load;
               if (req_last) begin
                  state_in = (count_after_load > CNT_W'(1)) ? ST_SUB : ST_DONE;
               end
            end
         end
         ST_SUB: begin
            // front two leave the chain, their difference is registered for the insert step that follows
            diff_in  = value[0] - value[1];
            cmd.op   = CELL_SHIFT2;
            count_in = count_ff - CNT_W'(2);
            state_in = ST_INS;
         end
         ST_INS: begin
            cmd.op   = CELL_INSERT;
            count_in = count_ff + 1'b1;
            state_in = (count_ff != '0) ? ST_SUB : ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_residue_in    = (count_ff == '0) ? '0 : value[0];
               rsp_overflowed_in = dropped_ff;
               count_in          = '0;
               dropped_in        = 1'b0;
               state_in          = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff          <= state_in;
         count_ff          <= count_in;
         dropped_ff        <= dropped_in;
         diff_ff           <= diff_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_residue_ff    <= rsp_residue_in;
         rsp_overflowed_ff <= rsp_overflowed_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_residue    = rsp_residue_ff;
   assign rsp_overflowed = rsp_overflowed_ff;

   // chain never holds more than its cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_NUMBERS))
      else $error("count exceeds capacity");

   // the front of the chain is sorted and holds at least two numbers when subtracting
   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB) |-> (count_ff >= CNT_W'(2) && value[0] >= value[1]))
      else $error("front of chain not sorted at subtract");

   // handing off a result empties the set and returns to loading
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready))
      |=> (rsp_valid_ff && count_ff == '0 && !dropped_ff && state_ff == ST_LOAD))
      else $error("set not cleared after result");

   // a new result beat only comes out of the done step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside done step");

endmodule

/* bench/largest_differencing_partition_tb.sv */
// self-checking testbench for the largest differencing partition block
`timescale 1ns / 1ps

module largest_differencing_partition_tb import lpd_pkg::*; ();

   localparam int MAX_NUMBERS = 128;
   localparam int PHASE_BEATS = 412;     // random beats per idling phase
   localparam int DRAIN_LIMIT = 20000;   // cycles allowed for the last results
   localparam int SETTLE_CYCLES = 300;   // covers differencing of a full chain

   // one result beat: residue plus drop flag
   typedef struct packed {
      value_type residue;
      logic      overflowed;
   } partition_result_type;

   // one directed beat; result is typed in only where typed_ok is set
   typedef struct packed {
      value_type            value;
      logic                 last;
      logic                 typed_ok;
      partition_result_type result;
   } directed_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_value = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_residue;
   logic        rsp_overflowed;

   // idling knobs, changed per phase by the stimulus process
   int send_idle_pct = 0;
   int stall_pct = 0;

   int error_count = 0;

   // predictor state: numbers of the open set and its drop flag
   value_type held_numbers[$];
   logic      set_dropped = 1'b0;

   // residues still owed by the block, oldest first
   partition_result_type pending_residues[$];

   // directed beats: single numbers, extremes, ties, sorted and unsorted sets
   directed_row_type directed_rows [0:24] = '{
      // single zero
      '{64'h0, 1'b1, 1'b1, '{64'h0, 1'b0}},
      // single maximum
      '{64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, '{64'hffff_ffff_ffff_ffff, 1'b0}},
      // two maxima cancel
      '{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, '{64'h0, 1'b0}},
      // maximum against zero
      '{64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'h0, 1'b1, 1'b1, '{64'hffff_ffff_ffff_ffff, 1'b0}},
      // top bit alone
      '{64'h8000_0000_0000_0000, 1'b1, 1'b1, '{64'h8000_0000_0000_0000, 1'b0}},
      // descending set
      '{64'd8, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd7, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd6, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd5, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd4, 1'b1, 1'b0, '{64'h0, 1'b0}},
      // three-way tie
      '{64'd3, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd3, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd3, 1'b1, 1'b0, '{64'h0, 1'b0}},
      // wide bit patterns
      '{64'h0123_4567_89ab_cdef, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'hfedc_ba98_7654_3210, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'h0000_0001_0000_0000, 1'b1, 1'b0, '{64'h0, 1'b0}},
      // ascending set, same numbers as the descending one
      '{64'd4, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd5, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd6, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd7, 1'b0, 1'b0, '{64'h0, 1'b0}},
      '{64'd8, 1'b1, 1'b0, '{64'h0, 1'b0}}
   };

   largest_differencing_partition #(
      .MAX_NUMBERS(MAX_NUMBERS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_residue    (rsp_residue),
      .rsp_overflowed (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // runaway guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // accepted number goes into the open set while there is room; a last beat closes it and
   // returns the karmarkar-karp residue of what the store kept
   task automatic load_number(input value_type number, input logic closes,
                              output logic done, output partition_result_type res);
      value_type work[$];
      value_type top [2];
      int best;
      done = 1'b0;
      res = '0;
      if (held_numbers.size() < MAX_NUMBERS) begin
         held_numbers = {held_numbers, number};
      end else begin
         // store full: number dropped, even when it is the last one
         set_dropped = 1'b1;
      end
      if (closes) begin
         work = held_numbers;
         // take the two largest, put back their difference
         while (work.size() > 1) begin
            for (int pick = 0; pick < 2; pick++) begin
               best = 0;
               for (int k = 1; k < work.size(); k++) begin
                  if (work[k] > work[best]) begin
                     best = k;
                  end
               end
               top[pick] = work[best];
               work.delete(best);
            end
            work = {work, value_type'(top[0] - top[1])};
         end
         res.residue = (work.size() == 0) ? '0 : work[0];
         res.overflowed = set_dropped;
         done = 1'b1;
         held_numbers.delete();
         set_dropped = 1'b0;
      end
   endtask

   // drive one beat, with a random gap in front, and wait for its acceptance
   task automatic send_number(input value_type number, input logic closes,
                              input logic typed_ok, input partition_result_type typed);
      logic done;
      partition_result_type predicted;
      // gap: valid low for whole cycles, never lowered and raised in one step
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= number;
      req_last  <= closes;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      load_number(number, closes, done, predicted);
      if (done) begin
         pending_residues = {pending_residues, (typed_ok ? typed : predicted)};
      end
   endtask

   // random 64-bit numbers mixed with zeros, maxima, small values and ties
   function automatic value_type pick_number(input value_type prior);
      value_type number;
      case ($urandom_range(0, 9))
         0: number = '0;
         1: number = '1;
         2: number = value_type'($urandom_range(0, 15));
         3: number = prior;
         4: number = {1'b1, 31'($urandom), 32'($urandom)};
         5: number = prior + value_type'($urandom_range(0, 3));
         default: number = {32'($urandom), 32'($urandom)};
      endcase
      return number;
   endfunction

   // receiver: stall at random according to the phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // every result beat is matched against the oldest owed residue
   always @(posedge clock) begin : residue_check
      partition_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_residues.size() == 0) begin
            $error("unexpected result beat: residue %h overflowed %b",
                   rsp_residue, rsp_overflowed);
            error_count++;
         end else begin
            want = pending_residues.pop_front();
            if (rsp_residue !== want.residue) begin
               $error("residue: expected %h, actual %h", want.residue, rsp_residue);
               error_count++;
            end
            if (rsp_overflowed !== want.overflowed) begin
               $error("overflowed: expected %b, actual %b",
                      want.overflowed, rsp_overflowed);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int set_size;
      int phase_beats;
      int roll;
      int drain_cycles;
      value_type number;
      logic first_set;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling
      foreach (directed_rows[i]) begin
         send_number(directed_rows[i].value, directed_rows[i].last,
                     directed_rows[i].typed_ok, directed_rows[i].result);
      end

      // random sets under four idling phases:
      // none, sender idle, receiver stalling, both a little
      number = '0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         phase_beats = 0;
         first_set = 1'b1;
         while (phase_beats < PHASE_BEATS) begin
            roll = $urandom_range(0, 99);
            if (first_set && ph == 1) begin
               set_size = MAX_NUMBERS;          // exactly full, nothing dropped
            end else if (first_set && ph == 2) begin
               set_size = MAX_NUMBERS + 1;      // only the last beat dropped
            end else if (first_set && ph == 3) begin
               set_size = MAX_NUMBERS + 3;      // several beats dropped
            end else if (roll < 3) begin
               set_size = $urandom_range(MAX_NUMBERS - 2, MAX_NUMBERS + 7);
            end else if (roll < 15) begin
               set_size = $urandom_range(9, 40);
            end else begin
               set_size = $urandom_range(1, 8);
            end
            first_set = 1'b0;
            for (int n = 0; n < set_size; n++) begin
               number = pick_number(number);
               send_number(number, (n == set_size - 1), 1'b0, '0);
            end
            phase_beats += set_size;
         end
      end
      req_valid <= 1'b0;

      // wait for every owed residue, then let the block settle
      drain_cycles = 0;
      while (pending_residues.size() > 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (pending_residues.size() > 0) begin
         $error("residues never delivered: %0d", pending_residues.size());
         error_count++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/lpd_pkg.sv
sv/lpd_cell.sv
sv/largest_differencing_partition.sv
bench/largest_differencing_partition_tb.sv
